@@ rtl/core/trc_pkg.sv @@
// shared constants, codes and control structs of the register calculator
package trc_pkg;

  localparam int XLEN       = 32;
  localparam int REG_COUNT  = 10;
  localparam int PROG_DEPTH = 256;
  localparam int REG_IDX_W  = $clog2(REG_COUNT);
  localparam int PC_W       = $clog2(PROG_DEPTH);
  localparam int CMD_W      = 4;
  localparam int DIDX_W     = 4;
  localparam int NPC_W      = 8;
  localparam int STAT_W     = 3;
  localparam int STEP_W     = $clog2(XLEN);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_MUL    = 4'd2,
    CMD_DIV    = 4'd3,
    CMD_MOVE   = 4'd4,
    CMD_CMP    = 4'd5,
    CMD_BRANCH = 4'd6,
    CMD_JUMP   = 4'd7,
    CMD_HALT   = 4'd8
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_DIV0   = 3'd1,
    ST_BADCMD = 3'd2,
    ST_HALT   = 3'd3,
    ST_BADREG = 3'd4
  } status_t;

  // request to the multiply / divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  // status back from the multiply / divide unit
  typedef struct packed {
    logic done;
    logic busy;
  } md_rsp_t;

endpackage

@@ rtl/core/trc_chan_if.sv @@
// valid / ready channels for instructions and results
interface trc_in_if import trc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic              first_is_register;
  logic [XLEN-1:0]   first_value;
  logic              second_is_register;
  logic [XLEN-1:0]   second_value;

  modport source (
    output valid, command, first_is_register, first_value,
           second_is_register, second_value,
    input  ready
  );
  modport sink (
    input  valid, command, first_is_register, first_value,
           second_is_register, second_value,
    output ready
  );
endinterface

interface trc_out_if import trc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              wrote_register;
  logic [DIDX_W-1:0] dest_index;
  logic [XLEN-1:0]   dest_value;
  logic [NPC_W-1:0]  next_pc;
  logic [STAT_W-1:0] status;

  modport source (
    output valid, wrote_register, dest_index, dest_value, next_pc, status,
    input  ready
  );
  modport sink (
    input  valid, wrote_register, dest_index, dest_value, next_pc, status,
    output ready
  );
endinterface

@@ rtl/core/trc_mdu.sv @@
// iterative multiply / signed divide around one shared adder
module trc_mdu import trc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  md_req_t         req,
  input  logic [XLEN-1:0] op_a,
  input  logic [XLEN-1:0] op_b,
  output md_rsp_t         rsp,
  output logic [XLEN-1:0] res
);

  localparam int AW = XLEN + 2;

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_ABSA = 5'b00010,
    M_ABSB = 5'b00100,
    M_RUN  = 5'b01000,
    M_FIX  = 5'b10000
  } mstate_t;

  mstate_t           state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r;
  logic              done_r;
  logic              is_div_r, neg_a_r, neg_b_r;
  logic [XLEN-1:0]   acc_r, opa_r, opb_r;

  logic [AW-1:0]     add_x, add_y, sum;
  logic              add_sub;
  logic              ge;
  logic              last;

  // shared adder: x + y or x - y, on subtract a clear top bit means x >= y
  assign sum  = add_x + (add_sub ? ~add_y : add_y) + AW'(add_sub);
  assign ge   = !sum[AW-1];
  assign last = (cnt_r == STEP_W'(XLEN - 1));

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      M_ABSA: begin
        add_y   = {2'b00, opa_r};
        add_sub = 1'b1;
      end
      M_ABSB: begin
        add_y   = {2'b00, opb_r};
        add_sub = 1'b1;
      end
      M_RUN: begin
        if (is_div_r) begin
          add_x   = {1'b0, acc_r, opa_r[XLEN-1]};
          add_y   = {2'b00, opb_r};
          add_sub = 1'b1;
        end else begin
          add_x = {2'b00, acc_r};
          add_y = {2'b00, opb_r};
        end
      end
      M_FIX: begin
        add_y   = {2'b00, opa_r};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      M_IDLE: if (req.start) state_nxt = req.is_div ? M_ABSA : M_RUN;
      M_ABSA: state_nxt = M_ABSB;
      M_ABSB: state_nxt = M_RUN;
      M_RUN:  if (last) state_nxt = is_div_r ? M_FIX : M_IDLE;
      M_FIX:  state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (req.start) begin
        done_r <= 1'b0;
      end else if ((state_r == M_RUN && last && !is_div_r) || state_r == M_FIX) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == M_IDLE && req.start) begin
      is_div_r <= req.is_div;
      neg_a_r  <= op_a[XLEN-1];
      neg_b_r  <= op_b[XLEN-1];
      acc_r    <= '0;
      opa_r    <= op_a;
      opb_r    <= op_b;
      cnt_r    <= '0;
    end else begin
      unique case (state_r)
        M_ABSA: if (neg_a_r) opa_r <= sum[XLEN-1:0];
        M_ABSB: if (neg_b_r) opb_r <= sum[XLEN-1:0];
        M_RUN: begin
          cnt_r <= cnt_r + STEP_W'(1);
          if (is_div_r) begin
            // restoring step: partial remainder in acc, quotient shifts into opa
            acc_r <= ge ? sum[XLEN-1:0] : {acc_r[XLEN-2:0], opa_r[XLEN-1]};
            opa_r <= {opa_r[XLEN-2:0], ge};
          end else begin
            if (opa_r[0]) acc_r <= sum[XLEN-1:0];
            opa_r <= {1'b0, opa_r[XLEN-1:1]};
            opb_r <= {opb_r[XLEN-2:0], 1'b0};
          end
        end
        M_FIX: if (neg_a_r ^ neg_b_r) opa_r <= sum[XLEN-1:0];
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.busy = (state_r != M_IDLE);
  assign res      = is_div_r ? opa_r : acc_r;

endmodule

@@ rtl/core/tiny_register_calculator_exec.sv @@
// execute stage of the register calculator: register file, pc and sequencer
//
// One decoded instruction is taken per transfer on in_ch and produces exactly
// one result transfer on out_ch. Add, subtract, move, compare, branch, jump,
// halt and every error case are accepted in the idle state, which reads the
// register file, and then execute in the execute state. Multiply and divide
// run on a single shared 34-bit adder that retires one bit per cycle, and
// divide adds steps to take operand magnitudes before and to apply the
// quotient sign after. The register file is a 2-read / 1-write array read at
// the input transfer; its reset value of zero comes from one valid bit per
// register. A result sits in an output register, so the next instruction is
// accepted while the previous result still waits; a finished instruction
// holds until that slot is free. Faults (divide by zero, unknown command,
// bad register number, bad branch target) and halt leave registers and pc
// untouched.
module tiny_register_calculator_exec import trc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  trc_in_if.sink     in_ch,
  trc_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_ITER = 3'b100
  } state_t;

  // register number check: non-negative and below the register count
  function automatic logic reg_num_ok(input logic [XLEN-1:0] v);
    return !v[XLEN-1] && (v < XLEN'(REG_COUNT));
  endfunction

  state_t              state_r, state_nxt;

  // latched instruction
  logic [CMD_W-1:0]    cmd_r;
  logic                f_reg_r, s_reg_r;
  logic [XLEN-1:0]     v1_r, v2_r;

  // register file with per-entry valid bits standing in for reset
  logic [XLEN-1:0]     regs_mem [REG_COUNT];
  logic [REG_COUNT-1:0] reg_vld_r;
  logic [XLEN-1:0]     rd_a_r, rd_b_r;
  logic                rd_a_vld_r, rd_b_vld_r;
  logic [REG_IDX_W-1:0] ra, rb;

  logic [PC_W-1:0]     pc_r;
  logic [PC_W-1:0]     seq_pc, tgt_pc;

  // output slot
  logic                out_valid_r;
  logic                out_wrote_r;
  logic [REG_IDX_W-1:0] out_didx_r;
  logic [XLEN-1:0]     out_dval_r;
  logic [PC_W-1:0]     out_npc_r;
  status_t             out_status_r;

  logic                accept, slot_free, commit;
  logic                f_ok, s_ok, bad_reg, tgt_ok, md_go;
  logic [XLEN-1:0]     rd_a_val, op_a, op_b, alu_res;

  logic                 c_wrote;
  logic [REG_IDX_W-1:0] c_didx;
  logic [XLEN-1:0]      c_dval;
  logic [PC_W-1:0]      c_npc;
  status_t              c_status;

  md_req_t             md_req;
  md_rsp_t             md_rsp;
  logic [XLEN-1:0]     md_res;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  // read addresses come straight off the input payload; branch reads r0
  always_comb begin
    ra = '0;
    rb = '0;
    if (in_ch.command != CMD_BRANCH && reg_num_ok(in_ch.first_value)) begin
      ra = in_ch.first_value[REG_IDX_W-1:0];
    end
    if (reg_num_ok(in_ch.second_value)) begin
      rb = in_ch.second_value[REG_IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_ch.command;
      f_reg_r    <= in_ch.first_is_register;
      v1_r       <= in_ch.first_value;
      s_reg_r    <= in_ch.second_is_register;
      v2_r       <= in_ch.second_value;
      rd_a_r     <= regs_mem[ra];
      rd_b_r     <= regs_mem[rb];
      rd_a_vld_r <= reg_vld_r[ra];
      rd_b_vld_r <= reg_vld_r[rb];
    end
    if (commit && c_wrote) begin
      regs_mem[c_didx] <= c_dval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_vld_r <= '0;
    end else if (commit && c_wrote) begin
      reg_vld_r[c_didx] <= 1'b1;
    end
  end

  // operand fetch: a never-written register reads as zero
  assign rd_a_val = rd_a_vld_r ? rd_a_r : '0;
  assign op_a     = f_reg_r ? rd_a_val : v1_r;
  assign op_b     = s_reg_r ? (rd_b_vld_r ? rd_b_r : '0) : v2_r;

  assign f_ok   = reg_num_ok(v1_r);
  assign s_ok   = reg_num_ok(v2_r);
  // move always names its destination by the first operand
  assign bad_reg = ((cmd_r == CMD_MOVE) ? !f_ok : (f_reg_r && !f_ok)) || (s_reg_r && !s_ok);

  // sequential advance wraps at the program depth
  assign seq_pc = (pc_r == PC_W'(PROG_DEPTH - 1)) ? '0 : pc_r + PC_W'(1);
  // branch target is a 1-based line number
  assign tgt_ok = ($signed(v1_r) >= $signed(XLEN'(1)))
               && ($signed(v1_r) <= $signed(XLEN'(PROG_DEPTH)));
  assign tgt_pc = v1_r[PC_W-1:0] - PC_W'(1);

  always_comb begin
    unique case (cmd_r) inside
      CMD_ADD:  alu_res = op_a + op_b;
      CMD_SUB:  alu_res = op_a - op_b;
      CMD_CMP:  alu_res = XLEN'($signed(op_a) < $signed(op_b));
      CMD_MOVE: alu_res = op_b;
      default:  alu_res = '0;
    endcase
  end

  // result of the instruction in flight
  always_comb begin
    c_wrote  = 1'b0;
    c_didx   = '0;
    c_dval   = '0;
    c_npc    = pc_r;
    c_status = ST_OK;
    md_go    = 1'b0;
    if (state_r == S_ITER) begin
      c_wrote = 1'b1;
      c_dval  = md_res;
      c_npc   = seq_pc;
    end else begin
      unique case (cmd_r) inside
        CMD_ADD, CMD_SUB, CMD_MOVE, CMD_CMP: begin
          if (bad_reg) begin
            c_status = ST_BADREG;
          end else begin
            c_wrote = 1'b1;
            c_didx  = (cmd_r == CMD_MOVE) ? v1_r[REG_IDX_W-1:0] : '0;
            c_dval  = alu_res;
            c_npc   = seq_pc;
          end
        end
        CMD_MUL, CMD_DIV: begin
          // register errors win over divide by zero
          if (bad_reg) begin
            c_status = ST_BADREG;
          end else if (cmd_r == CMD_DIV && op_b == '0) begin
            c_status = ST_DIV0;
          end else begin
            md_go = 1'b1;
          end
        end
        CMD_BRANCH, CMD_JUMP: begin
          // an untaken branch does not look at its target
          if (cmd_r == CMD_BRANCH && rd_a_val != XLEN'(1)) begin
            c_npc = seq_pc;
          end else if (!tgt_ok) begin
            c_status = ST_BADREG;
          end else begin
            c_npc = tgt_pc;
          end
        end
        CMD_HALT: begin
          c_status = ST_HALT;
        end
        default: begin
          c_status = ST_BADCMD;
        end
      endcase
    end
  end

  assign md_req.start  = (state_r == S_EXEC) && md_go;
  assign md_req.is_div = (cmd_r == CMD_DIV);

  trc_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .op_a  (op_a),
    .op_b  (op_b),
    .rsp   (md_rsp),
    .res   (md_res)
  );

  // an instruction retires only into a free output slot
  assign commit = slot_free && (((state_r == S_EXEC) && !md_go)
                             || ((state_r == S_ITER) && md_rsp.done));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: begin
        if (md_go) begin
          state_nxt = S_ITER;
        end else if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      S_ITER: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        pc_r        <= c_npc;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_wrote_r  <= c_wrote;
      out_didx_r   <= c_didx;
      out_dval_r   <= c_dval;
      out_npc_r    <= c_npc;
      out_status_r <= c_status;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.wrote_register = out_wrote_r;
  assign out_ch.dest_index     = DIDX_W'(out_didx_r);
  assign out_ch.dest_value     = out_dval_r;
  assign out_ch.next_pc        = NPC_W'(out_npc_r);
  assign out_ch.status         = out_status_r;

  // every accepted instruction goes straight to execute
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted instruction did not reach execute");

  // the shared unit is never restarted while it is working
  a_mdu_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    md_req.start |-> !md_rsp.busy)
    else $error("multiply/divide started while busy");

  // a register write is only ever reported with ok status
  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.wrote_register |-> out_ch.status == ST_OK)
    else $error("register write reported with fault status");

  // a retirement never overwrites a result still waiting in the slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> !out_valid_r || out_ch.ready)
    else $error("result slot overwritten before transfer");

  // pc stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PC_W'(PROG_DEPTH - 1))
    else $error("program counter out of range");

endmodule

@@ dv/trc_exec_check.sv @@
// result checker for the register calculator execute stage: predicts and compares every transfer
`timescale 1ns / 1ps

module trc_exec_check import trc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  trc_in_if    in_mon,
  trc_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   checked_count
);

  typedef struct packed {
    logic              wrote;
    logic [DIDX_W-1:0] idx;
    logic [XLEN-1:0]   value;
    logic [NPC_W-1:0]  npc;
    logic [STAT_W-1:0] status;
  } exec_result_t;

  logic [XLEN-1:0] reg_file [REG_COUNT];
  logic [PC_W-1:0] pc;
  exec_result_t    expected_q[$];
  int              n_fail;
  int              n_checked;

  function automatic logic reg_num_ok(logic [XLEN-1:0] num);
    return $signed(num) >= 0 && $signed(num) < REG_COUNT;
  endfunction

  // one instruction against the shadow register file and pc
  task automatic execute(input logic [CMD_W-1:0] cmd, input logic fir,
                         input logic [XLEN-1:0] fv, input logic sir,
                         input logic [XLEN-1:0] sv, output exec_result_t res);
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] val;
    logic [DIDX_W-1:0] idx;
    logic            ok_a;
    logic            ok_b;
    logic [PC_W-1:0] seq_pc;
    logic [PC_W-1:0] npc;
    longint          quo;
    status_t         st;
    res    = '0;
    st     = ST_OK;
    npc    = pc;
    seq_pc = (int'(pc) == PROG_DEPTH - 1) ? '0 : pc + 1'b1;
    val    = '0;
    idx    = '0;
    if (cmd <= CMD_CMP) begin
      ok_b = !sir || reg_num_ok(sv);
      b    = (sir && ok_b) ? reg_file[sv[REG_IDX_W-1:0]] : sv;
      // move takes the first operand as destination number regardless of its flag
      if (cmd == CMD_MOVE) begin
        ok_a = reg_num_ok(fv);
        a    = fv;
      end else begin
        ok_a = !fir || reg_num_ok(fv);
        a    = (fir && ok_a) ? reg_file[fv[REG_IDX_W-1:0]] : fv;
      end
      if (!ok_a || !ok_b) begin
        st = ST_BADREG;
      end else begin
        case (cmd)
          CMD_ADD: val = a + b;
          CMD_SUB: val = a - b;
          CMD_MUL: val = a * b;
          CMD_DIV: begin
            if (b == '0) begin
              st = ST_DIV0;
            end else begin
              quo = longint'($signed(a)) / longint'($signed(b));
              val = quo[XLEN-1:0];
            end
          end
          CMD_MOVE: begin
            idx = fv[DIDX_W-1:0];
            val = b;
          end
          default: val = ($signed(a) < $signed(b)) ? 1 : 0;
        endcase
        if (st == ST_OK) begin
          res.wrote = 1'b1;
          res.idx   = idx;
          res.value = val;
          reg_file[idx[REG_IDX_W-1:0]] = val;
          npc = seq_pc;
        end
      end
    end else if (cmd == CMD_BRANCH || cmd == CMD_JUMP) begin
      if (cmd == CMD_BRANCH && reg_file[0] != 1) begin
        npc = seq_pc;
      end else if ($signed(fv) < 1 || $signed(fv) > PROG_DEPTH) begin
        st = ST_BADREG;
      end else begin
        npc = PC_W'(fv - 1);
      end
    end else if (cmd == CMD_HALT) begin
      st = ST_HALT;
    end else begin
      st = ST_BADCMD;
    end
    pc         = npc;
    res.npc    = NPC_W'(npc);
    res.status = st;
  endtask

  always @(posedge clk) begin
    exec_result_t exp_res;
    exec_result_t got_res;
    if (!rst_n) begin
      foreach (reg_file[i]) reg_file[i] = '0;
      pc = '0;
      expected_q.delete();
      n_fail    = 0;
      n_checked = 0;
    end else begin
      // drain first: a result never belongs to an input taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        got_res = '{out_mon.wrote_register, out_mon.dest_index, out_mon.dest_value,
                    out_mon.next_pc, out_mon.status};
        if (expected_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result transfer wr=%0d idx=%0d val=%h npc=%0d st=%0d",
                   $realtime, got_res.wrote, got_res.idx, got_res.value, got_res.npc,
                   got_res.status);
        end else begin
          exp_res = expected_q.pop_front();
          n_checked++;
          if (got_res !== exp_res) begin
            n_fail++;
            $display("%0t: mismatch exp wr=%0d idx=%0d val=%h npc=%0d st=%0d",
                     $realtime, exp_res.wrote, exp_res.idx, exp_res.value, exp_res.npc,
                     exp_res.status);
            $display("%0t:          got wr=%0d idx=%0d val=%h npc=%0d st=%0d",
                     $realtime, got_res.wrote, got_res.idx, got_res.value, got_res.npc,
                     got_res.status);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        execute(in_mon.command, in_mon.first_is_register, in_mon.first_value,
                in_mon.second_is_register, in_mon.second_value, exp_res);
        expected_q.push_back(exp_res);
      end
    end
    fail_count    <= n_fail;
    checked_count <= n_checked;
    pending       <= expected_q.size();
  end

endmodule

@@ dv/tb_tiny_register_calculator_exec.sv @@
// top of the execute stage testbench: clock, reset, instruction stimulus and verdict
`timescale 1ns / 1ps

module tb_tiny_register_calculator_exec;
  import trc_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 50;      // divide is the slowest path
  localparam int CYCLE_LIMIT  = 500000;  // ~1750 items at worst-case pace, many times over

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             fir;
    logic [XLEN-1:0]  fv;
    logic             sir;
    logic [XLEN-1:0]  sv;
  } instr_t;

  logic clk;
  logic rst_n;
  int   cycles;
  int   fail_count;
  int   pending;
  int   checked_count;
  int   issued;
  logic hold_req;   // asks the receiver for one long hold-off
  logic steady;     // no idling on either side while set

  trc_in_if  in_ch();
  trc_out_if out_ch();

  tiny_register_calculator_exec dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  trc_exec_check u_exec_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // watchdog: a hung handshake ends the run here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still outstanding", cycles, pending);
    $display("[tiny_register_calculator_exec] ERROR");
    $finish;
  end

  function automatic instr_t mk(logic [CMD_W-1:0] cmd, logic fir, logic [XLEN-1:0] fv,
                                logic sir, logic [XLEN-1:0] sv);
    return '{cmd, fir, fv, sir, sv};
  endfunction

  // operand values lean on the arithmetic corners
  function automatic logic [XLEN-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 1;
      2:       return '1;
      3:       return {1'b1, {(XLEN-1){1'b0}}};
      4:       return {1'b0, {(XLEN-1){1'b1}}};
      5, 6:    return XLEN'($urandom_range(0, 32)) - 16;
      default: return $urandom;
    endcase
  endfunction

  // register numbers: mostly legal, sometimes just past the end, negative or wild
  function automatic logic [XLEN-1:0] rand_regnum();
    if ($urandom_range(0, 15) != 0) return $urandom_range(0, REG_COUNT - 1);
    case ($urandom_range(0, 2))
      0:       return $urandom_range(REG_COUNT, 15);
      1:       return -XLEN'($urandom_range(1, 4));
      default: return $urandom;
    endcase
  endfunction

  // branch targets: mostly legal 1-based lines, sometimes the edges just outside
  function automatic logic [XLEN-1:0] rand_target();
    if ($urandom_range(0, 7) != 0) return $urandom_range(1, PROG_DEPTH);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return PROG_DEPTH + 1;
      2:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t ins;
    int     pick;
    ins.fir = $urandom_range(0, 1);
    ins.sir = $urandom_range(0, 1);
    ins.fv  = $urandom;
    ins.sv  = $urandom;
    pick    = $urandom_range(0, 99);
    if      (pick < 12) ins.cmd = CMD_ADD;
    else if (pick < 22) ins.cmd = CMD_SUB;
    else if (pick < 30) ins.cmd = CMD_MUL;
    else if (pick < 38) ins.cmd = CMD_DIV;
    else if (pick < 55) ins.cmd = CMD_MOVE;
    else if (pick < 70) ins.cmd = CMD_CMP;
    else if (pick < 82) ins.cmd = CMD_BRANCH;
    else if (pick < 88) ins.cmd = CMD_JUMP;
    else if (pick < 93) ins.cmd = CMD_HALT;
    else                ins.cmd = CMD_W'($urandom_range(int'(CMD_HALT) + 1, 2**CMD_W - 1));
    case (ins.cmd) inside
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_CMP: begin
        ins.fv = ins.fir ? rand_regnum() : rand_operand();
        ins.sv = ins.sir ? rand_regnum() : rand_operand();
      end
      CMD_MOVE: begin
        // destination always comes from the first operand
        ins.fv = rand_regnum();
        ins.sv = ins.sir ? rand_regnum() : rand_operand();
      end
      CMD_BRANCH, CMD_JUMP: ins.fv = rand_target();
      default: ;  // halt and unknown commands keep their random operands
    endcase
    return ins;
  endfunction

  // offer one instruction after a random gap and wait for its transfer;
  // with no gap valid simply stays high into the next item
  task automatic send_instr(input instr_t ins);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.command            <= ins.cmd;
    in_ch.first_is_register  <= ins.fir;
    in_ch.first_value        <= ins.fv;
    in_ch.second_is_register <= ins.sir;
    in_ch.second_value       <= ins.sv;
    do @(posedge clk); while (!in_ch.ready);
    issued++;
  endtask

  // receiver: random stall before each result, plus one long hold-off on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        // counted here so the sender keeps offering and the block backs up
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        stall = steady ? 0 : $urandom_range(0, 4);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    issued   = 0;
    hold_req = 1'b0;
    steady   = 1'b0;
    rst_n                    <= 1'b0;
    in_ch.valid              <= 1'b0;
    in_ch.command            <= '0;
    in_ch.first_is_register  <= 1'b0;
    in_ch.first_value        <= '0;
    in_ch.second_is_register <= 1'b0;
    in_ch.second_value       <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_instr(mk(CMD_ADD, 1'b0, 7, 1'b0, -3));
    // move ignores the first operand flag
    send_instr(mk(CMD_MOVE, 1'b1, 1, 1'b0, 32'h7fff_ffff));
    send_instr(mk(CMD_MOVE, 1'b0, 2, 1'b0, 32'h8000_0000));
    send_instr(mk(CMD_MOVE, 1'b0, REG_COUNT - 1, 1'b0, -1));
    // wrap-around of add and subtract at the signed extremes
    send_instr(mk(CMD_ADD, 1'b1, 1, 1'b0, 1));
    send_instr(mk(CMD_SUB, 1'b1, 2, 1'b0, 1));
    send_instr(mk(CMD_MUL, 1'b1, 1, 1'b1, 1));
    send_instr(mk(CMD_MUL, 1'b0, -1, 1'b0, -1));
    // minimum over minus one wraps to the minimum
    send_instr(mk(CMD_DIV, 1'b1, 2, 1'b1, REG_COUNT - 1));
    send_instr(mk(CMD_DIV, 1'b0, -7, 1'b0, 2));
    send_instr(mk(CMD_DIV, 1'b0, 7, 1'b0, 0));
    // a bad register number outranks the zero divisor
    send_instr(mk(CMD_DIV, 1'b1, REG_COUNT, 1'b0, 0));
    send_instr(mk(CMD_CMP, 1'b0, -1, 1'b0, 1));
    // R0 is now one: taken branches, first to line 1, then to the out-of-range line 0
    send_instr(mk(CMD_BRANCH, 1'b0, 1, 1'b0, 0));
    send_instr(mk(CMD_BRANCH, 1'b1, 0, 1'b1, 99));
    send_instr(mk(CMD_JUMP, 1'b0, PROG_DEPTH + 1, 1'b0, 0));
    send_instr(mk(CMD_JUMP, 1'b0, PROG_DEPTH, 1'b0, 0));
    // pc at the last line: sequential advance wraps to zero
    send_instr(mk(CMD_ADD, 1'b0, 0, 1'b0, 0));
    send_instr(mk(CMD_CMP, 1'b0, 5, 1'b0, 3));
    // untaken branch never looks at its target
    send_instr(mk(CMD_BRANCH, 1'b0, 0, 1'b0, 0));
    send_instr(mk(CMD_HALT, 1'b1, -1, 1'b1, -1));
    // nothing is latched by halt
    send_instr(mk(CMD_SUB, 1'b0, 1, 1'b0, 2));
    send_instr(mk(CMD_W'(int'(CMD_HALT) + 1), 1'b0, 0, 1'b0, 0));
    send_instr(mk({CMD_W{1'b1}}, 1'b1, '1, 1'b1, '1));
    send_instr(mk(CMD_MOVE, 1'b0, REG_COUNT, 1'b0, 5));
    send_instr(mk(CMD_MOVE, 1'b0, -1, 1'b0, 5));
    send_instr(mk(CMD_ADD, 1'b0, 0, 1'b1, -1));

    // random mix with the pressure phases placed along the way
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 400) hold_req = 1'b1;
      if (i == 900) begin
        // sender pause until every outstanding result has come back
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      if (i == 1200) steady = 1'b1;
      if (i == 1400) steady = 1'b0;
      send_instr(rand_instr());
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d instructions issued (directed corners, then random mix), %0d results checked",
             issued, checked_count);
    $display("run: included a %0d-cycle receiver hold-off, a full drain pause and a gap-free stretch",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("[tiny_register_calculator_exec] OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("[tiny_register_calculator_exec] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/trc_pkg.sv
rtl/core/trc_chan_if.sv
rtl/core/trc_mdu.sv
rtl/core/tiny_register_calculator_exec.sv
dv/trc_exec_check.sv
dv/tb_tiny_register_calculator_exec.sv
